/* design/psq_pkg.sv */
// Shared types and constants for the priority sorted process queue.
// No dependencies; imported by the controller, the datapath and the top level.
package psq_pkg;

    // Sizing of the ordered list
    localparam int MAX_ENTRIES    = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int ID_SLOTS       = 16;
    localparam int IDX_W          = $clog2(MAX_ENTRIES);
    localparam int CNT_W          = $clog2(MAX_ENTRIES + 1);

    // Operation codes carried by a request
    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_POP      = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_CONTAINS = 3'd3,
        OP_PEEK     = 3'd4
    } op_t;

    // Which list entry the single read port looks at
    typedef enum logic [1:0] {
        RD_HERE = 2'd0,
        RD_NEXT = 2'd1,
        RD_PREV = 2'd2
    } rd_mode_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FIND,
        ST_CLOSE,
        ST_NEXT,
        ST_SEEK,
        ST_OPEN,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     capture;
        rd_mode_t rd_mode;
        logic     idx_clear;
        logic     idx_inc;
        logic     idx_dec;
        logic     idx_load_count;
        logic     pos_save;
        logic     shift_down;
        logic     shift_up;
        logic     place;
        logic     count_dec;
        logic     flag_clear_id;
        logic     flag_clear_head;
        logic     set_found;
        logic     rid_head;
        logic     rid_zero;
        logic     load_result;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic flag_hit;
        logic id_match;
        logic idx_last;
        logic seek_go;
        logic idx_gt_pos;
        logic empty;
        logic full;
        logic out_busy;
    } stat_t;

endpackage

/* design/psq_ctrl.sv */
// Controller state machine of the priority sorted process queue.
// Depends on psq_pkg; drives the datapath by cmd_t and reads stat_t.
module psq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  psq_pkg::stat_t stat,
    output psq_pkg::cmd_t  cmd
);
    import psq_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Work out the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.op)
                    OP_INSERT:   state_next = stat.flag_hit ? ST_FIND : ST_NEXT;
                    OP_POP:      state_next = stat.empty ? ST_DONE : ST_CLOSE;
                    OP_REMOVE:   state_next = stat.flag_hit ? ST_FIND : ST_DONE;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_FIND:
            begin
                if (stat.id_match)
                begin
                    state_next = ST_CLOSE;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_CLOSE:
            begin
                if (stat.idx_last)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (stat.op == OP_INSERT && !stat.full)
                begin
                    state_next = ST_SEEK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SEEK:
            begin
                if (!stat.seek_go)
                begin
                    state_next = ST_OPEN;
                end
            end
            ST_OPEN:
            begin
                if (!stat.idx_gt_pos)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive commands for the datapath
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_DECODE:
            begin
                cmd.idx_clear = 1'b1;
                case (stat.op)
                    OP_INSERT, OP_REMOVE, OP_CONTAINS:
                    begin
                        cmd.set_found = stat.flag_hit;
                    end
                    OP_POP:
                    begin
                        cmd.set_found       = !stat.empty;
                        cmd.rid_head        = !stat.empty;
                        cmd.rid_zero        = stat.empty;
                        cmd.flag_clear_head = !stat.empty;
                    end
                    OP_PEEK:
                    begin
                        cmd.set_found = !stat.empty;
                        cmd.rid_head  = !stat.empty;
                        cmd.rid_zero  = stat.empty;
                    end
                    default:
                    begin
                        cmd.set_found = 1'b0;
                    end
                endcase
            end
            ST_FIND:
            begin
                cmd.rd_mode       = RD_HERE;
                cmd.flag_clear_id = stat.id_match;
                cmd.idx_inc       = !stat.id_match && !stat.idx_last;
            end
            ST_CLOSE:
            begin
                cmd.rd_mode    = RD_NEXT;
                cmd.shift_down = !stat.idx_last;
                cmd.idx_inc    = !stat.idx_last;
                cmd.count_dec  = stat.idx_last;
            end
            ST_NEXT:
            begin
                cmd.idx_clear = 1'b1;
            end
            ST_SEEK:
            begin
                cmd.rd_mode        = RD_HERE;
                cmd.idx_inc        = stat.seek_go;
                cmd.pos_save       = !stat.seek_go;
                cmd.idx_load_count = !stat.seek_go;
            end
            ST_OPEN:
            begin
                cmd.rd_mode  = RD_PREV;
                cmd.shift_up = stat.idx_gt_pos;
                cmd.idx_dec  = stat.idx_gt_pos;
                cmd.place    = !stat.idx_gt_pos;
            end
            ST_DONE:
            begin
                cmd.load_result = !stat.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* design/psq_datapath.sv */
// Datapath of the priority sorted process queue: ordered list, membership
// flags, walk index and result register. Depends on psq_pkg.
module psq_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  psq_pkg::cmd_t  cmd,
    output psq_pkg::stat_t stat,
    input  logic [2:0]     operation,
    input  logic [3:0]     process_id,
    input  logic [7:0]     priority_req,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           found,
    output logic [3:0]     result_id,
    output logic           empty_res,
    output logic [4:0]     entry_count
);
    import psq_pkg::*;

    logic [3:0]                ids_reg   [MAX_ENTRIES];
    logic [PRIORITY_WIDTH-1:0] prios_reg [MAX_ENTRIES];
    logic [ID_SLOTS-1:0]       flags_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          pos_reg;

    op_t                       op_reg;
    logic [3:0]                id_reg;
    logic [PRIORITY_WIDTH-1:0] prio_reg;
    logic                      found_reg;
    logic [3:0]                rid_reg;

    logic                      out_valid_reg;
    logic                      out_found_reg;
    logic [3:0]                out_rid_reg;
    logic                      out_empty_reg;
    logic [4:0]                out_count_reg;

    logic [PRIORITY_WIDTH+7:0] prio_ext;
    logic [CNT_W-1:0]          rd_pos;
    logic [CNT_W-1:0]          wr_pos;
    logic [3:0]                rd_id;
    logic [PRIORITY_WIDTH-1:0] rd_prio;
    logic [CNT_W:0]            idx_plus;
    logic [CNT_W+4:0]          count_ext;

    // Keep the low priority bits of the request
    assign prio_ext = {{PRIORITY_WIDTH{1'b0}}, priority_req};

    // Select the single read address of the list
    always_comb
    begin
        case (cmd.rd_mode)
            RD_NEXT: rd_pos = idx_reg + 1'b1;
            RD_PREV: rd_pos = idx_reg - 1'b1;
            default: rd_pos = idx_reg;
        endcase
    end

    assign rd_id    = ids_reg[rd_pos[IDX_W-1:0]];
    assign rd_prio  = prios_reg[rd_pos[IDX_W-1:0]];
    assign wr_pos   = cmd.place ? pos_reg : idx_reg;
    assign idx_plus = {1'b0, idx_reg} + 1'b1;

    // Report status to the controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.flag_hit   = flags_reg[id_reg];
        stat.id_match   = (rd_id == id_reg);
        stat.idx_last   = (idx_plus >= {1'b0, count_reg});
        stat.seek_go    = (idx_reg < count_reg) && (prio_reg < rd_prio);
        stat.idx_gt_pos = (idx_reg > pos_reg);
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg == CNT_W'(MAX_ENTRIES));
        stat.out_busy   = out_valid_reg && out_stall;
    end

    // Capture the request fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(operation);
            id_reg   <= process_id;
            prio_reg <= prio_ext[PRIORITY_WIDTH-1:0];
        end
    end

    // Build the working result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            found_reg <= 1'b0;
            rid_reg   <= process_id;
        end
        else
        begin
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.rid_head)
            begin
                rid_reg <= ids_reg[0];
            end
            else if (cmd.rid_zero)
            begin
                rid_reg <= '0;
            end
        end
    end

    // Advance the walk index and hold the insert position
    always_ff @(posedge clk)
    begin
        if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_load_count)
        begin
            idx_reg <= count_reg;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        else if (cmd.idx_dec)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.pos_save)
        begin
            pos_reg <= idx_reg;
        end
    end

    // Shift entries and place the new id
    always_ff @(posedge clk)
    begin
        if (cmd.shift_down || cmd.shift_up)
        begin
            ids_reg[wr_pos[IDX_W-1:0]]   <= rd_id;
            prios_reg[wr_pos[IDX_W-1:0]] <= rd_prio;
        end
        else if (cmd.place)
        begin
            ids_reg[wr_pos[IDX_W-1:0]]   <= id_reg;
            prios_reg[wr_pos[IDX_W-1:0]] <= prio_reg;
        end
    end

    // Track the entry count and the membership flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flags_reg <= '0;
        end
        else
        begin
            if (cmd.count_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.place)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.flag_clear_head)
            begin
                flags_reg[ids_reg[0]] <= 1'b0;
            end
            if (cmd.flag_clear_id)
            begin
                flags_reg[id_reg] <= 1'b0;
            end
            if (cmd.place)
            begin
                flags_reg[id_reg] <= 1'b1;
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign count_ext = {5'b0, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_found_reg <= found_reg;
            out_rid_reg   <= rid_reg;
            out_empty_reg <= (count_reg == '0);
            out_count_reg <= count_ext[4:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign result_id   = out_rid_reg;
    assign empty_res   = out_empty_reg;
    assign entry_count = out_count_reg;

endmodule

/* design/priority_sorted_process_queue_unit.sv */
// Top level of the priority sorted process queue.
// Depends on psq_pkg, psq_ctrl and psq_datapath.
//
// Keeps up to MAX_ENTRIES process ids in descending priority order, newest
// first among equal priorities. One request on the input channel (operation,
// process_id, priority_req) gives exactly one result on the output channel
// (found, result_id, empty_res, entry_count).
// Both channels use valid/stall; a request is taken when in_valid is high
// and in_stall low, a result when out_valid is high and out_stall low.
// One request is in flight at a time: in_stall stays high from the cycle
// after acceptance until the result has been written to the output register.
// Contains, peek, unknown codes, pop of an empty queue and remove of an absent
// id give their result without a list walk; pop, remove and insert walk the
// list, which reads one entry and shifts one entry per cycle.
// The next request can be taken in the cycle after the result is written.
// A result waiting under out_stall does not block the next request; only its
// completion waits for the output register to free up.
// Reset empties the queue and clears all membership flags at once.
module priority_sorted_process_queue_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] operation,
    input  logic [3:0] process_id,
    input  logic [7:0] priority_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       found,
    output logic [3:0] result_id,
    output logic       empty_res,
    output logic [4:0] entry_count
);
    import psq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    psq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    psq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .process_id   (process_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .result_id    (result_id),
        .empty_res    (empty_res),
        .entry_count  (entry_count)
    );

endmodule

/* design/psq_checker.sv */
// Port-level checks for the priority sorted process queue, with its bind.
// Depends on psq_pkg and priority_sorted_process_queue_unit.
module psq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       found,
    input logic [3:0] result_id,
    input logic       empty_res,
    input logic [4:0] entry_count
);
    import psq_pkg::*;

    // Only one request is in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while another was in flight");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_res == (entry_count == 5'd0)))
        else $error("empty flag disagrees with entry count");

    // Count never exceeds the list depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(entry_count) <= MAX_ENTRIES))
        else $error("entry count beyond list depth");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(found)
            && $stable(result_id) && $stable(empty_res) && $stable(entry_count)))
        else $error("stalled result changed");

endmodule

bind priority_sorted_process_queue_unit psq_checker u_psq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .result_id   (result_id),
    .empty_res   (empty_res),
    .entry_count (entry_count)
);

/* test/priority_sorted_process_queue_unit_test.sv */
// Self-checking testbench for the priority sorted process queue unit.
// Depends on psq_pkg and priority_sorted_process_queue_unit; a directed table
// runs first, then random sessions, checked against a queue model or typed row literals.
module priority_sorted_process_queue_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import psq_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RANDOM_ITEMS  = 350;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_LIMIT  = 10;

    // Codes outside the defined set; the block treats them as no-ops
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    typedef struct packed {
        logic             found;
        logic [3:0]       rid;
        logic             empty;
        logic [CNT_W-1:0] count;
    } queue_result_t;

    typedef struct packed {
        logic [2:0]    op;
        logic [3:0]    id;
        logic [7:0]    prio;
        logic          typed;
        queue_result_t want;
    } directed_row_t;

    localparam int DIRECTED_LEN = 24;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [2:0] operation    = '0;
    logic [3:0] process_id   = '0;
    logic [7:0] priority_req = '0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic       found;
    logic [3:0] result_id;
    logic       empty_res;
    logic [4:0] entry_count;

    priority_sorted_process_queue_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .process_id   (process_id),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .result_id    (result_id),
        .empty_res    (empty_res),
        .entry_count  (entry_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Directed requests; typed rows carry a result that is obvious by inspection
    directed_row_t directed_rows [0:DIRECTED_LEN-1] = '{
        '{OP_POP,      4'd0,  8'd0,   1'b1, '{1'b0, 4'd0,  1'b1, 5'd0}},
        '{OP_PEEK,     4'd3,  8'd0,   1'b1, '{1'b0, 4'd0,  1'b1, 5'd0}},
        '{OP_REMOVE,   4'd15, 8'd0,   1'b1, '{1'b0, 4'd15, 1'b1, 5'd0}},
        '{OP_CONTAINS, 4'd0,  8'd0,   1'b1, '{1'b0, 4'd0,  1'b1, 5'd0}},
        '{OP_SPARE_C,  4'd9,  8'd255, 1'b1, '{1'b0, 4'd9,  1'b1, 5'd0}},
        '{OP_INSERT,   4'd0,  8'd0,   1'b1, '{1'b0, 4'd0,  1'b0, 5'd1}},
        '{OP_INSERT,   4'd15, 8'd255, 1'b1, '{1'b0, 4'd15, 1'b0, 5'd2}},
        '{OP_PEEK,     4'd0,  8'd0,   1'b1, '{1'b1, 4'd15, 1'b0, 5'd2}},
        '{OP_INSERT,   4'd5,  8'd255, 1'b0, '0},
        '{OP_PEEK,     4'd0,  8'd0,   1'b0, '0},
        '{OP_INSERT,   4'd10, 8'd0,   1'b0, '0},
        '{OP_INSERT,   4'd15, 8'd0,   1'b0, '0},
        '{OP_CONTAINS, 4'd15, 8'd0,   1'b0, '0},
        '{OP_INSERT,   4'd7,  8'd128, 1'b0, '0},
        '{OP_REMOVE,   4'd7,  8'd0,   1'b0, '0},
        '{OP_REMOVE,   4'd7,  8'd0,   1'b0, '0},
        '{OP_CONTAINS, 4'd7,  8'd0,   1'b0, '0},
        '{OP_SPARE_A,  4'd6,  8'd170, 1'b0, '0},
        '{OP_SPARE_B,  4'd12, 8'd85,  1'b0, '0},
        '{OP_POP,      4'd0,  8'd0,   1'b0, '0},
        '{OP_POP,      4'd0,  8'd0,   1'b0, '0},
        '{OP_POP,      4'd0,  8'd0,   1'b0, '0},
        '{OP_POP,      4'd0,  8'd0,   1'b0, '0},
        '{OP_POP,      4'd0,  8'd0,   1'b1, '{1'b0, 4'd0,  1'b1, 5'd0}}
    };

    // Model of the ordered list, head first
    logic [3:0]                queue_ids   [MAX_ENTRIES];
    logic [PRIORITY_WIDTH-1:0] queue_prios [MAX_ENTRIES];
    int                        queue_len = 0;
    logic                      member      [ID_SLOTS];

    queue_result_t pending_results [$];

    int  error_count   = 0;
    int  results_seen  = 0;
    int  requests_sent = 0;
    int  peak_len      = 0;
    int  op_tally [8];
    int  stall_left    = 0;
    int  idle_cycles   = 0;
    bit  steady_run    = 1'b0;
    bit  valid_high    = 1'b0;

    function automatic void log_failure(string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("[%0t] %s", $realtime, what);
    endfunction

    // Close the gap left by the entry at pos
    function automatic void drop_at(int pos);
        for (int i = pos; i + 1 < queue_len; i++)
        begin
            queue_ids[i]   = queue_ids[i + 1];
            queue_prios[i] = queue_prios[i + 1];
        end
        queue_len--;
    endfunction

    // Take the id out of the list if queued; report whether it was
    function automatic logic take_out(logic [3:0] id);
        for (int i = 0; i < queue_len; i++)
        begin
            if (queue_ids[i] == id)
            begin
                drop_at(i);
                member[id] = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one request to the model and give the result it produces
    function automatic queue_result_t apply_request(logic [2:0] op, logic [3:0] id,
                                                    logic [7:0] prio_in);
        queue_result_t             r;
        logic [PRIORITY_WIDTH-1:0] prio;
        int                        pos;
        prio    = PRIORITY_WIDTH'(prio_in);
        r.found = 1'b0;
        r.rid   = id;
        case (op)
            OP_INSERT:
            begin
                r.found = take_out(id);
                if (queue_len < MAX_ENTRIES)
                begin
                    // place ahead of the first entry with lower or equal priority
                    pos = 0;
                    while (pos < queue_len && prio < queue_prios[pos])
                        pos++;
                    for (int i = queue_len; i > pos; i--)
                    begin
                        queue_ids[i]   = queue_ids[i - 1];
                        queue_prios[i] = queue_prios[i - 1];
                    end
                    queue_ids[pos]   = id;
                    queue_prios[pos] = prio;
                    queue_len++;
                    member[id] = 1'b1;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (queue_len > 0)
                begin
                    r.found = 1'b1;
                    r.rid   = queue_ids[0];
                    if (op == OP_POP)
                    begin
                        member[r.rid] = 1'b0;
                        drop_at(0);
                    end
                end
                else
                    r.rid = 4'd0;
            end
            OP_REMOVE:   r.found = take_out(id);
            OP_CONTAINS: r.found = member[id];
            default: ;
        endcase
        r.empty = (queue_len == 0);
        r.count = CNT_W'(queue_len);
        return r;
    endfunction

    // Offer one request after a random gap, none in a steady run, and hold it until taken
    task automatic send_request(logic [2:0] op, logic [3:0] id, logic [7:0] prio,
                                logic typed, queue_result_t literal);
        int            gap;
        queue_result_t predicted;
        gap = steady_run ? 0 : $urandom_range(0, 9);
        if (gap != 0 && valid_high)
        begin
            in_valid   <= 1'b0;
            valid_high  = 1'b0;
        end
        repeat (gap) @(posedge clk);
        in_valid     <= 1'b1;
        operation    <= op;
        process_id   <= id;
        priority_req <= prio;
        valid_high    = 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = apply_request(op, id, prio);
        pending_results.push_back(typed ? literal : predicted);
        requests_sent++;
        op_tally[op]++;
        if (queue_len > peak_len)
            peak_len = queue_len;
    endtask

    // Hold off the sender until every outstanding result has arrived
    task automatic wait_for_results();
        if (valid_high)
        begin
            in_valid   <= 1'b0;
            valid_high  = 1'b0;
        end
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Take results, check against the oldest expectation, then draw a stall
    always @(posedge clk)
    begin
        queue_result_t got;
        queue_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.found = found;
            got.rid   = result_id;
            got.empty = empty_res;
            got.count = entry_count;
            results_seen++;
            if (pending_results.size() == 0)
                log_failure($sformatf(
                    "result with no pending request: found=%0d id=%0d empty=%0d count=%0d",
                    got.found, got.rid, got.empty, got.count));
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    log_failure($sformatf({"mismatch: expected found=%0d id=%0d ",
                        "empty=%0d count=%0d, got found=%0d id=%0d empty=%0d count=%0d"},
                        want.found, want.rid, want.empty, want.count,
                        got.found, got.rid, got.empty, got.count));
            end
            stall_left = steady_run ? 0 : $urandom_range(0, 9);
        end
        else if (stall_left != 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no request or result moved in %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus: reset, directed table, random sessions, drain
    initial
    begin
        int          random_done;
        int          session_mode;
        int          session_len;
        int          roll;
        logic [2:0]  op;
        logic [3:0]  id;
        logic [7:0]  prio;
        random_done = 0;
        for (int i = 0; i < ID_SLOTS; i++)
            member[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            op_tally[i] = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int i = 0; i < DIRECTED_LEN; i++)
            send_request(directed_rows[i].op, directed_rows[i].id, directed_rows[i].prio,
                         directed_rows[i].typed, directed_rows[i].want);
        wait_for_results();

        // random sessions: fill-heavy, drain-heavy or mixed, each ending when all results are in
        while (random_done < RANDOM_ITEMS)
        begin
            session_mode = $urandom_range(0, 2);
            steady_run   = ($urandom_range(0, 3) == 0);
            session_len  = $urandom_range(10, 40);
            repeat (session_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
                else
                begin
                    roll = $urandom_range(0, 99);
                    case (session_mode)
                        0:       op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_POP :
                                      (roll < 87) ? OP_REMOVE : (roll < 94) ? OP_CONTAINS :
                                      OP_PEEK;
                        1:       op = (roll < 25) ? OP_INSERT : (roll < 65) ? OP_POP :
                                      (roll < 78) ? OP_REMOVE : (roll < 88) ? OP_CONTAINS :
                                      OP_PEEK;
                        default: op = (roll < 40) ? OP_INSERT : (roll < 60) ? OP_POP :
                                      (roll < 75) ? OP_REMOVE : (roll < 88) ? OP_CONTAINS :
                                      OP_PEEK;
                    endcase
                end
                id = 4'($urandom_range(0, 15));
                // a third of priorities come from a coarse set to force ties
                if ($urandom_range(0, 2) == 0)
                    prio = 8'($urandom_range(0, 3) * 85);
                else
                    prio = 8'($urandom_range(0, 255));
                send_request(op, id, prio, 1'b0, '0);
                if (op <= OP_PEEK)
                    random_done++;
            end
            wait_for_results();
        end
        steady_run = 1'b0;

        // let any late or stray result show up
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests (%0d directed, %0d random), %0d results, %0d failures",
                 requests_sent, DIRECTED_LEN, requests_sent - DIRECTED_LEN,
                 results_seen, error_count);
        $display({"insert %0d, pop %0d, remove %0d, contains %0d, peek %0d, ",
                  "no-op %0d, peak depth %0d"},
                 op_tally[OP_INSERT], op_tally[OP_POP], op_tally[OP_REMOVE],
                 op_tally[OP_CONTAINS], op_tally[OP_PEEK],
                 op_tally[OP_SPARE_A] + op_tally[OP_SPARE_B] + op_tally[OP_SPARE_C],
                 peak_len);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
